// File: rtl/pcrq_pkg.sv
package pcrq_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W  = 32;
  localparam int ENTRY_W   = 8;
  localparam int QUANT_W   = 33;
  localparam int CHAN_W    = 8;
  localparam int DIM_W     = 16;
  localparam int NCH_W     = 9;
  localparam int SHIFT_W   = 6;
  localparam int PROD_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Item kinds carried in tuser.
  localparam logic OP_SAMPLE      = 1'b0;
  localparam logic OP_SCALE_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_IMAGES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BITS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_UNSIGNED = 3'd6;

  // Output format settings that the arithmetic pipeline needs.
  typedef struct packed {
    logic [SHIFT_W-1:0] frac_bits;
    logic [SHIFT_W-1:0] out_bits;
    logic               out_unsigned;
  } fmt_t;

  // Side information that travels with each sample.
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              last;
  } tag_t;

endpackage

// File: rtl/pcrq_datapath.sv
module pcrq_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic signed [pcrq_pkg::SAMPLE_W-1:0] s_sample,
  input  logic signed [pcrq_pkg::SAMPLE_W-1:0] s_scale,
  input  pcrq_pkg::tag_t                 s_tag,
  input  pcrq_pkg::fmt_t                 fmt,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic [pcrq_pkg::QUANT_W-1:0]   m_quantized,
  output pcrq_pkg::tag_t                 m_tag
);
  import pcrq_pkg::*;

  logic                     va_r, vb_r, vc_r, vd_r;
  logic                     ld_a, ld_b, ld_c, ld_d;
  logic signed [PROD_W-1:0] prod_r, sum_r, shifted_r;
  logic signed [PROD_W-1:0] sum_nxt, lo, hi;
  logic        [PROD_W-1:0] rnd;
  logic        [SHIFT_W-1:0] obits;
  logic [QUANT_W-1:0]       quant_r, quant_nxt;
  tag_t                     tag_a_r, tag_b_r, tag_c_r, tag_d_r;

  // Each stage refills whenever it is empty or its successor moves, so
  // bubbles collapse while the output is stalled.
  assign ld_d    = !vd_r || m_ready;
  assign ld_c    = !vc_r || ld_d;
  assign ld_b    = !vb_r || ld_c;
  assign ld_a    = !va_r || ld_b;
  assign s_ready = ld_a;

  always_comb begin
    if (fmt.frac_bits == '0) begin
      rnd = '0;
    end else begin
      rnd = PROD_W'(1) << (fmt.frac_bits - SHIFT_W'(1));
    end
    sum_nxt = prod_r + $signed(rnd);
  end

  always_comb begin
    if (fmt.out_bits == '0) begin
      obits = SHIFT_W'(1);
    end else if (fmt.out_bits > SHIFT_W'(32)) begin
      obits = SHIFT_W'(32);
    end else begin
      obits = fmt.out_bits;
    end
    if (fmt.out_unsigned) begin
      lo = '0;
      hi = $signed((PROD_W'(1) << obits) - PROD_W'(1));
    end else begin
      lo = -$signed(PROD_W'(1) << (obits - SHIFT_W'(1)));
      hi = $signed((PROD_W'(1) << (obits - SHIFT_W'(1))) - PROD_W'(1));
    end
    if (shifted_r < lo) begin
      quant_nxt = lo[QUANT_W-1:0];
    end else if (shifted_r > hi) begin
      quant_nxt = hi[QUANT_W-1:0];
    end else begin
      quant_nxt = shifted_r[QUANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ld_a) begin
        va_r <= s_valid;
      end
      if (ld_b) begin
        vb_r <= va_r;
      end
      if (ld_c) begin
        vc_r <= vb_r;
      end
      if (ld_d) begin
        vd_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      prod_r  <= PROD_W'(s_sample) * PROD_W'(s_scale);
      tag_a_r <= s_tag;
    end
    if (ld_b) begin
      sum_r   <= sum_nxt;
      tag_b_r <= tag_a_r;
    end
    if (ld_c) begin
      shifted_r <= sum_r >>> fmt.frac_bits;
      tag_c_r   <= tag_b_r;
    end
    if (ld_d) begin
      quant_r <= quant_nxt;
      tag_d_r <= tag_c_r;
    end
  end

  assign m_valid     = vd_r;
  assign m_quantized = quant_r;
  assign m_tag       = tag_d_r;

endmodule

// File: rtl/per_channel_fixed_point_requantizer_core.sv
// Per-channel requantizer for a stream of signed 32-bit accumulator values.
// The input channel carries two kinds of transactions, told apart by
// in_tuser: a sample, or a write of one channel's signed scale into the
// scale table. Samples arrive image by image, channel by channel, then row
// by row and column by column; internal position counters supply the channel
// and flag the final sample of the batch on out_tlast.
// Each sample is multiplied by its channel's scale, rounded by half an LSB,
// shifted right by frac_bits and saturated to an out_bits-wide signed or
// unsigned range. Scale writes produce no output transaction.
// Throughput is one transaction per cycle while the receiver keeps up. A
// result reaches the output through the scale table read register, then
// the multiply, round, shift and clamp stages.
// When the receiver stalls, the stages keep filling until every register
// holds a result, and only then is in_tready dropped.
// Reset clears the position counters, the pipeline and the registers to
// their defaults; the scale table holds no defined value until written.
// Configuration may only be written while no sample is in flight.
module per_channel_fixed_point_requantizer_core #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,  // sample_or_scale[31:0], entry[39:32]
  input  logic                            in_tuser,  // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata, // quantized[32:0], channel[40:33], zero
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [pcrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcrq_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import pcrq_pkg::*;

  localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int XW     = (AW > ENTRY_W) ? AW : ENTRY_W;
  localparam int CH_MAX = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

  // Configuration registers.
  logic [NCH_W-1:0]   num_channels_r;
  logic [DIM_W-1:0]   plane_height_r, plane_width_r, batch_images_r;
  logic [SHIFT_W-1:0] frac_bits_r, out_bits_r;
  logic               out_unsigned_r;

  // Position counters.
  logic [DIM_W-1:0]   col_r, row_r, img_r, col_nxt, row_nxt, img_nxt;
  logic [CHAN_W-1:0]  chan_r, chan_nxt;

  logic [SAMPLE_W-1:0] scale_mem [MAX_CHANNELS];

  logic                in_accept, is_sample, wr_in_range;
  logic [XW-1:0]       rd_ext, wr_ext;
  logic [DIM_W-1:0]    pw1, ph1, nb1;
  logic [NCH_W-1:0]    nch;
  logic                col_end, row_end, ch_end, img_end;

  logic                v1_r, dp_ready, dp_valid;
  logic signed [SAMPLE_W-1:0] sample_r, scale_r;
  tag_t                tag_r, tag_nxt, dp_tag;
  fmt_t                fmt;
  logic [QUANT_W-1:0]  dp_quant;

  assign in_accept   = in_tvalid && in_tready;
  assign is_sample   = (in_tuser == OP_SAMPLE);
  assign in_tready   = !v1_r || dp_ready;
  assign rd_ext      = XW'(chan_r);
  assign wr_ext      = XW'(in_tdata[39:32]);
  assign wr_in_range = 32'(in_tdata[39:32]) < 32'(MAX_CHANNELS);

  // A zero dimension counts as one; the channel count is capped by the table.
  always_comb begin
    pw1 = (plane_width_r  == '0) ? DIM_W'(1) : plane_width_r;
    ph1 = (plane_height_r == '0) ? DIM_W'(1) : plane_height_r;
    nb1 = (batch_images_r == '0) ? DIM_W'(1) : batch_images_r;
    if (num_channels_r == '0) begin
      nch = NCH_W'(1);
    end else if (32'(num_channels_r) > 32'(CH_MAX)) begin
      nch = NCH_W'(CH_MAX);
    end else begin
      nch = num_channels_r;
    end
  end

  // A counter at or past its limit wraps, which also covers limits that
  // were lowered between runs.
  always_comb begin
    col_end = col_r >= pw1 - DIM_W'(1);
    row_end = row_r >= ph1 - DIM_W'(1);
    ch_end  = NCH_W'(chan_r) >= nch - NCH_W'(1);
    img_end = img_r >= nb1 - DIM_W'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    img_nxt  = img_r;
    if (col_end) begin
      col_nxt = '0;
      if (row_end) begin
        row_nxt = '0;
        if (ch_end) begin
          chan_nxt = '0;
          img_nxt  = img_end ? '0 : img_r + DIM_W'(1);
        end else begin
          chan_nxt = chan_r + CHAN_W'(1);
        end
      end else begin
        row_nxt = row_r + DIM_W'(1);
      end
    end else begin
      col_nxt = col_r + DIM_W'(1);
    end
    tag_nxt.channel = chan_r;
    tag_nxt.last    = col_end && row_end && ch_end && img_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_channels_r <= NCH_W'(1);
      plane_height_r <= DIM_W'(1);
      plane_width_r  <= DIM_W'(1);
      batch_images_r <= DIM_W'(1);
      frac_bits_r    <= '0;
      out_bits_r     <= SHIFT_W'(8);
      out_unsigned_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CHANNELS: num_channels_r <= cfg_wdata[NCH_W-1:0];
        CFG_PLANE_HEIGHT: plane_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_PLANE_WIDTH:  plane_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_BATCH_IMAGES: batch_images_r <= cfg_wdata[DIM_W-1:0];
        CFG_FRAC_BITS:    frac_bits_r    <= cfg_wdata[SHIFT_W-1:0];
        CFG_OUT_BITS:     out_bits_r     <= cfg_wdata[SHIFT_W-1:0];
        CFG_OUT_UNSIGNED: out_unsigned_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
      img_r  <= '0;
      v1_r   <= 1'b0;
    end else begin
      if (in_accept && is_sample) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        chan_r <= chan_nxt;
        img_r  <= img_nxt;
      end
      if (in_tready) begin
        v1_r <= in_accept && is_sample;
      end
    end
  end

  // The table is written and read only on accepted transactions, one per
  // cycle, so a scale write is always visible to any later sample.
  always_ff @(posedge clk) begin
    if (in_accept && !is_sample && wr_in_range) begin
      scale_mem[wr_ext[AW-1:0]] <= in_tdata[SAMPLE_W-1:0];
    end
    if (in_accept && is_sample) begin
      scale_r  <= scale_mem[rd_ext[AW-1:0]];
      sample_r <= in_tdata[SAMPLE_W-1:0];
      tag_r    <= tag_nxt;
    end
  end

  assign fmt.frac_bits    = frac_bits_r;
  assign fmt.out_bits     = out_bits_r;
  assign fmt.out_unsigned = out_unsigned_r;

  pcrq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (v1_r),
    .s_ready     (dp_ready),
    .s_sample    (sample_r),
    .s_scale     (scale_r),
    .s_tag       (tag_r),
    .fmt         (fmt),
    .m_valid     (dp_valid),
    .m_ready     (out_tready),
    .m_quantized (dp_quant),
    .m_tag       (dp_tag)
  );

  assign out_tvalid = dp_valid;
  assign out_tdata  = {7'b0, dp_tag.channel, dp_quant};
  assign out_tlast  = dp_tag.last;

endmodule

// File: tb/tb_per_channel_fixed_point_requantizer_core.sv
module tb_per_channel_fixed_point_requantizer_core;
  import pcrq_pkg::*;

  typedef struct packed {
    logic [32:0] quant;
    logic [7:0]  chan;
    logic        last;
  } requant_t;

  class requant_scoreboard;
    requant_t    pending_quant[$];
    logic [31:0] scale_mem[256];
    bit          scale_valid[256];
    int unsigned col_pos, row_pos, chan_pos, img_pos;
    int unsigned num_ch, height, width, batch, frac, obits;
    bit          uns;
    int unsigned mismatches, results_seen, n_samples, n_writes;

    function new();
      num_ch = 1;
      height = 1;
      width = 1;
      batch = 1;
      frac = 0;
      obits = 8;
      uns = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_NUM_CHANNELS: num_ch = val[8:0];
        CFG_PLANE_HEIGHT: height = val;
        CFG_PLANE_WIDTH:  width = val;
        CFG_BATCH_IMAGES: batch = val;
        CFG_FRAC_BITS:    frac = val[5:0];
        CFG_OUT_BITS:     obits = val[5:0];
        CFG_OUT_UNSIGNED: uns = val[0];
        default: ;
      endcase
    endfunction

    // Works out the expected result of an accepted sample; table writes only
    // update the scale table.
    function void note_input(logic op, logic [39:0] data);
      int          sample, scale;
      longint      acc, lo, hi;
      int unsigned nch, w1, h1, b1, b;
      bit          col_end, row_end, ch_end, img_end;
      requant_t    e;
      if (op == OP_SCALE_WRITE) begin
        scale_mem[data[39:32]] = data[31:0];
        scale_valid[data[39:32]] = 1'b1;
        n_writes++;
        return;
      end
      n_samples++;
      nch = (num_ch == 0) ? 1 : num_ch;
      if (nch > 256) nch = 256;
      w1 = (width == 0) ? 1 : width;
      h1 = (height == 0) ? 1 : height;
      b1 = (batch == 0) ? 1 : batch;

      sample = data[31:0];
      scale = scale_mem[chan_pos];
      acc = sample;
      acc = acc * scale;
      if (frac > 0) acc = acc + (64'sd1 <<< (frac - 1));
      acc = acc >>> frac;

      b = obits;
      if (b == 0) b = 1;
      if (b > 32) b = 32;
      if (uns) begin
        lo = 0;
        hi = (64'sd1 <<< b) - 1;
      end else begin
        lo = -(64'sd1 <<< (b - 1));
        hi = (64'sd1 <<< (b - 1)) - 1;
      end
      if (acc < lo) acc = lo;
      if (acc > hi) acc = hi;

      col_end = col_pos >= w1 - 1;
      row_end = row_pos >= h1 - 1;
      ch_end = chan_pos >= nch - 1;
      img_end = img_pos >= b1 - 1;
      e.quant = acc[32:0];
      e.chan = chan_pos[7:0];
      e.last = col_end && row_end && ch_end && img_end;
      pending_quant.push_back(e);

      // A counter that sits past its limit after a register rewrite wraps
      // just like one at its end.
      if (col_end) begin
        col_pos = 0;
        if (row_end) begin
          row_pos = 0;
          if (ch_end) begin
            chan_pos = 0;
            if (img_end) img_pos = 0;
            else img_pos++;
          end else chan_pos++;
        end else row_pos++;
      end else col_pos++;
    endfunction

    function void check_result(logic [32:0] q, logic [7:0] c, logic l);
      requant_t e;
      results_seen++;
      if (pending_quant.size() == 0) begin
        $display("%0t: result with nothing expected: quantized %h channel %0d last %b",
                 $time, q, c, l);
        mismatches++;
        return;
      end
      e = pending_quant.pop_front();
      if (q !== e.quant) begin
        $display("%0t: quantized mismatch: expected %h, actual %h", $time, e.quant, q);
        mismatches++;
      end
      if (c !== e.chan) begin
        $display("%0t: channel mismatch: expected %0d, actual %0d", $time, e.chan, c);
        mismatches++;
      end
      if (l !== e.last) begin
        $display("%0t: last mismatch: expected %b, actual %b", $time, e.last, l);
        mismatches++;
      end
    endfunction
  endclass

  localparam int PIPE_DRAIN = 10;
  localparam int HOLD_CYCLES = 48;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;  // sample_or_scale[31:0], entry[39:32]
  logic                 in_tuser;  // operation
  logic                 out_tvalid;
  logic                 out_tready;
  logic [47:0]          out_tdata; // quantized[32:0], channel[40:33], zero
  logic                 out_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  bit                   idle_on;
  bit                   long_hold;
  int unsigned          in_stalls;
  int unsigned          n_formats;
  requant_scoreboard    sb;

  always #6 clk = ~clk;

  per_channel_fixed_point_requantizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (in_tvalid && !in_tready) in_stalls++;
      if (out_tvalid && out_tready) sb.check_result(out_tdata[32:0], out_tdata[40:33], out_tlast);
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready = 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 0;
      3: v = -1;
      4, 5: v = int'($urandom_range(0, 511)) - 256;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_dim(input int unsigned typical_max);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  // All stimulus tasks start and return at a falling edge. After send_item
  // returns, in_tvalid is still high, so the caller either sends the next
  // transaction right away or lowers it.
  task automatic send_item(input logic op, input logic [31:0] value, input logic [7:0] entry);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {entry, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Never lets a sample read a scale entry that has not been written.
  task automatic send_sample(input logic [31:0] value);
    if (!sb.scale_valid[sb.chan_pos])
      send_item(OP_SCALE_WRITE, pick_value(), sb.chan_pos[7:0]);
    send_item(OP_SAMPLE, value, 8'($urandom));
  endtask

  // Table writes in flight give no result, so the task goes on waiting for the pipeline to drain.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.pending_quant.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DAT_W-1:0];
    sb.write_reg(idx, val[CFG_DAT_W-1:0]);
    @(negedge clk);
  endtask

  task automatic set_format(input int unsigned nch, h, w, nb, f, ob, uns);
    wait_idle();
    write_cfg(CFG_NUM_CHANNELS, nch);
    write_cfg(CFG_PLANE_HEIGHT, h);
    write_cfg(CFG_PLANE_WIDTH, w);
    write_cfg(CFG_BATCH_IMAGES, nb);
    write_cfg(CFG_FRAC_BITS, f);
    write_cfg(CFG_OUT_BITS, ob);
    write_cfg(CFG_OUT_UNSIGNED, uns);
    cfg_we = 1'b0;
    n_formats++;
  endtask

  initial begin
    int unsigned r_nch, r_frac, r_ob;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_SAMPLE;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_CHANNELS;
    cfg_wdata = '0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset format: extreme samples against small and extreme scales.
    send_item(OP_SCALE_WRITE, 32'd3, 8'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd42);
    send_sample(-32'sd43);
    send_item(OP_SCALE_WRITE, 32'h8000_0000, 8'd0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_item(OP_SCALE_WRITE, 32'h7FFF_FFFF, 8'd0);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);

    // Zero dimensions and zero output width, with a shift of 62.
    set_format(0, 0, 0, 0, 62, 0, 0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    // Too many channels, an over-wide output, unsigned clamp, exact half rounding.
    set_format(300, 1, 1, 1, 1, 40, 1);
    send_sample(32'd1);
    send_sample(32'd3);
    send_sample(-32'sd3);
    send_sample(32'd5);
    send_sample(32'h7FFF_FFFF);

    // The channel counter now sits past the new channel count and must wrap.
    set_format(2, 3, 3, 2, 4, 16, 0);
    send_sample(32'd1000);
    send_sample(-32'sd1000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0: r_nch = 0;
        1: r_nch = 256;
        2: r_nch = $urandom_range(257, 511);
        default: r_nch = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 5))
        0: r_frac = 0;
        1: r_frac = 62;
        default: r_frac = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 7))
        0: r_ob = 0;
        1: r_ob = 32;
        2: r_ob = 1;
        3: r_ob = $urandom_range(33, 63);
        default: r_ob = $urandom_range(1, 32);
      endcase
      set_format(r_nch, pick_dim(4), pick_dim(4), pick_dim(3), r_frac, r_ob,
                 $urandom_range(0, 1));
      idle_on = (p < NUM_PHASES - 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 1 && i == 30) long_hold = 1'b1;
        if (p == 3 && i == 75) wait_idle();
        if ($urandom_range(0, 7) == 0) send_item(OP_SCALE_WRITE, pick_value(), 8'($urandom));
        else send_sample(pick_value());
      end
    end

    wait_idle();
    $display("Requantized %0d samples and applied %0d scale-table writes across %0d formats.",
             sb.n_samples, sb.n_writes, n_formats);
    $display("Checked %0d results; input held off for %0d cycles by output back-pressure.",
             sb.results_seen, in_stalls);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
